// ===== hdl/tafs_pkg.sv =====
package tafs_pkg;

  // timestamp and duration width, arithmetic modulo 2^TIME_W
  localparam int TIME_W = 32;

  // alpha, quotient, divide bit index and product widths
  localparam int ALPHA_W = 8;
  localparam int QUO_W   = 8;
  localparam int BIT_W   = $clog2(QUO_W);
  localparam int PROD_W  = TIME_W + QUO_W;

  // reset duration
  localparam logic [TIME_W-1:0] DEFAULT_DURATION = TIME_W'(1000);
  localparam logic [ALPHA_W-1:0] ALPHA_ZERO = 8'h00;

  // operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_FADE_IN  = 2'd1;
  localparam logic [1:0] OP_FADE_OUT = 2'd2;
  localparam logic [1:0] OP_DEACT    = 2'd3;

  // input beat
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] color_argb;
    logic [31:0] fade_length;
    logic [31:0] now_time;
  } item_t;

  // result beat
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       is_active;
    logic       is_ready;
    logic       overlay_visible;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic             load_item;
    logic             calc_elapsed;
    logic             load_product;
    logic             div_step;
    logic [BIT_W-1:0] div_bit;
    logic             commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/tafs_ctrl.sv =====
module tafs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tafs_pkg::status_t status,
  output tafs_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ELAP = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [tafs_pkg::BIT_W-1:0] bit_r, bit_nxt;

  // sequencing of one item
  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    in_stall  = 1'b1;
    cmd.div_bit = bit_r;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_ELAP;
        end
      end
      S_ELAP: begin
        cmd.calc_elapsed = 1'b1;
        state_nxt        = S_MUL;
      end
      S_MUL: begin
        if (status.need_div) begin
          cmd.load_product = 1'b1;
          bit_nxt          = tafs_pkg::BIT_W'(tafs_pkg::QUO_W - 1);
          state_nxt        = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          bit_nxt = bit_r - tafs_pkg::BIT_W'(1);
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // last division step leads to the update
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && bit_r == '0) |=> state_r == S_DONE)
    else $error("division did not end in update");

  // items only enter while idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> state_r == S_ELAP)
    else $error("accepted item did not start evaluation");

  // nothing is committed without a free output slot
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status.out_free)
    else $error("commit while output occupied");

endmodule

// ===== hdl/tafs_datapath.sv =====
module tafs_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  tafs_pkg::item_t   in_data,
  input  tafs_pkg::cmd_t    cmd,
  output tafs_pkg::status_t status,
  input  logic              out_stall,
  output logic              out_valid,
  output tafs_pkg::result_t out_data
);

  tafs_pkg::item_t                  item_r;
  logic                             active_r, active_nxt;
  logic                             ready_r, ready_nxt;
  logic [7:0]                       red_r, red_nxt;
  logic [7:0]                       green_r, green_nxt;
  logic [7:0]                       blue_r, blue_nxt;
  logic [tafs_pkg::ALPHA_W-1:0]     alpha_r, alpha_nxt;
  logic [tafs_pkg::ALPHA_W-1:0]     start_r, start_nxt;
  logic [tafs_pkg::ALPHA_W-1:0]     end_r, end_nxt;
  logic [tafs_pkg::TIME_W-1:0]      dur_r, dur_nxt;
  logic [tafs_pkg::TIME_W-1:0]      tstart_r, tstart_nxt;
  logic [tafs_pkg::TIME_W-1:0]      elapsed_r, elapsed_nxt;
  logic                             past_r;
  logic [tafs_pkg::PROD_W-1:0]      rem_r;
  logic [tafs_pkg::QUO_W-1:0]       quo_r;
  logic                             out_valid_r;
  tafs_pkg::result_t                out_data_r, result_nxt;

  logic                             rising;
  logic [tafs_pkg::ALPHA_W-1:0]     span;
  logic [tafs_pkg::PROD_W-1:0]      trial;
  logic [tafs_pkg::ALPHA_W-1:0]     step_dn;
  logic [tafs_pkg::ALPHA_W-1:0]     tick_alpha;

  // elapsed time and fade direction
  assign elapsed_nxt = tafs_pkg::TIME_W'(item_r.now_time) - tstart_r;
  assign rising      = end_r >= start_r;
  assign span        = rising ? (end_r - start_r) : (start_r - end_r);
  assign trial       = tafs_pkg::PROD_W'(dur_r) << cmd.div_bit;

  // status toward the controller
  assign status.need_div = (item_r.operation == tafs_pkg::OP_TICK) && active_r && !past_r;
  assign status.out_free = !out_valid_r || !out_stall;

  // interpolated alpha for a running tick
  assign step_dn    = quo_r + tafs_pkg::ALPHA_W'(rem_r != '0);
  assign tick_alpha = rising ? (start_r + quo_r) : (start_r - step_dn);

  // next architectural state for the item
  always_comb begin
    active_nxt = active_r;
    ready_nxt  = ready_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    alpha_nxt  = alpha_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    dur_nxt    = dur_r;
    tstart_nxt = tstart_r;
    unique case (item_r.operation) inside
      tafs_pkg::OP_TICK: begin
        if (active_r) begin
          ready_nxt = past_r;
          alpha_nxt = past_r ? end_r : tick_alpha;
          if (past_r && end_r == tafs_pkg::ALPHA_ZERO) begin
            active_nxt = 1'b0;
          end
        end
      end
      tafs_pkg::OP_FADE_IN, tafs_pkg::OP_FADE_OUT: begin
        ready_nxt  = 1'b0;
        active_nxt = 1'b1;
        red_nxt    = item_r.color_argb[23:16];
        green_nxt  = item_r.color_argb[15:8];
        blue_nxt   = item_r.color_argb[7:0];
        dur_nxt    = tafs_pkg::TIME_W'(item_r.fade_length);
        tstart_nxt = tafs_pkg::TIME_W'(item_r.now_time);
        if (item_r.operation == tafs_pkg::OP_FADE_IN) begin
          start_nxt = item_r.color_argb[31:24];
          end_nxt   = tafs_pkg::ALPHA_ZERO;
        end else begin
          start_nxt = alpha_r;
          end_nxt   = item_r.color_argb[31:24];
        end
      end
      tafs_pkg::OP_DEACT: begin
        active_nxt = 1'b0;
        ready_nxt  = 1'b1;
      end
      default: begin
        active_nxt = active_r;
      end
    endcase
    result_nxt.red_out         = red_nxt;
    result_nxt.green_out       = green_nxt;
    result_nxt.blue_out        = blue_nxt;
    result_nxt.alpha_out       = alpha_nxt;
    result_nxt.is_active       = active_nxt;
    result_nxt.is_ready        = ready_nxt;
    result_nxt.overlay_visible = active_nxt && (alpha_nxt != tafs_pkg::ALPHA_ZERO);
  end

  // item, elapsed time, product and restoring divider
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.calc_elapsed) begin
      elapsed_r <= elapsed_nxt;
      past_r    <= elapsed_nxt >= dur_r;
    end
    if (cmd.load_product) begin
      rem_r <= tafs_pkg::PROD_W'(elapsed_r) * tafs_pkg::PROD_W'(span);
      quo_r <= '0;
    end else if (cmd.div_step && rem_r >= trial) begin
      rem_r              <= rem_r - trial;
      quo_r[cmd.div_bit] <= 1'b1;
    end
    if (cmd.commit) begin
      out_data_r <= result_nxt;
    end
  end

  // fader state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      ready_r     <= 1'b0;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      alpha_r     <= tafs_pkg::ALPHA_ZERO;
      start_r     <= '0;
      end_r       <= '0;
      dur_r       <= tafs_pkg::DEFAULT_DURATION;
      tstart_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        active_r    <= active_nxt;
        ready_r     <= ready_nxt;
        red_r       <= red_nxt;
        green_r     <= green_nxt;
        blue_r      <= blue_nxt;
        alpha_r     <= alpha_nxt;
        start_r     <= start_nxt;
        end_r       <= end_nxt;
        dur_r       <= dur_nxt;
        tstart_r    <= tstart_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a committed item always shows a beat
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed item produced no beat");

  // visible overlay needs an active fader with nonzero alpha
  a_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.overlay_visible) |->
      (out_data_r.is_active && out_data_r.alpha_out != tafs_pkg::ALPHA_ZERO))
    else $error("overlay visible while inactive or transparent");

  // deactivate leaves the fader stopped and ready
  a_deact: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && item_r.operation == tafs_pkg::OP_DEACT) |=> (!active_r && ready_r))
    else $error("deactivate did not stop the fader");

endmodule

// ===== hdl/timed_alpha_fade_sequencer.sv =====
// sequence: a tick on an active fade that has not reached its duration passes
// through elapsed, multiply, 8 restoring divide steps and update before its result
// beat; other items skip multiply and divide. flow: one item at a time, next
// accepted the cycle after the update, which waits for a free output slot
// reset: synchronous active-low; fader inactive, alpha and colour 0,
// duration 1000, no result pending
module timed_alpha_fade_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tafs_pkg::item_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tafs_pkg::result_t out_data
);

  tafs_pkg::cmd_t    cmd;
  tafs_pkg::status_t status;

  // sequencer
  tafs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // fade arithmetic and state
  tafs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tafs_tb_pkg.sv =====
`timescale 1ns / 1ps

package tafs_tb_pkg;
  import tafs_pkg::*;

  class fade_scoreboard;
    // mirrored fader state
    logic               act;
    logic               rdy;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [ALPHA_W-1:0] alpha;
    logic [ALPHA_W-1:0] src_alpha;
    logic [ALPHA_W-1:0] dst_alpha;
    logic [TIME_W-1:0]  dur;
    logic [TIME_W-1:0]  t0;

    // overlay results still owed by the block, oldest first
    result_t expected_overlay[$];
    int errors;

    function new();
      act       = 1'b0;
      rdy       = 1'b0;
      red       = '0;
      green     = '0;
      blue      = '0;
      alpha     = ALPHA_ZERO;
      src_alpha = '0;
      dst_alpha = '0;
      dur       = DEFAULT_DURATION;
      t0        = '0;
      errors    = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // advance the mirrored fader by one accepted input beat
    function void note_beat(item_t it);
      logic [TIME_W-1:0] elapsed;
      logic [7:0]        span;
      longint unsigned   prod;
      longint unsigned   quo;
      int unsigned       a;
      result_t           want;
      case (it.operation)
        OP_TICK: begin
          if (act) begin
            elapsed = it.now_time - t0;
            if (elapsed >= dur) begin
              a   = dst_alpha;
              rdy = 1'b1;
            end else begin
              rdy = 1'b0;
              if (dst_alpha >= src_alpha) begin
                span = dst_alpha - src_alpha;
                prod = 64'(elapsed) * 64'(span);
                quo  = prod / 64'(dur);
                a    = src_alpha + int'(quo);
              end else begin
                // falling fade rounds the step toward lower alpha
                span = src_alpha - dst_alpha;
                prod = 64'(elapsed) * 64'(span);
                quo  = prod / 64'(dur);
                if (prod % 64'(dur) != 0) quo++;
                a    = src_alpha - int'(quo);
              end
            end
            if (a > 255) a = 255;
            alpha = a[7:0];
            if (rdy && alpha == ALPHA_ZERO) act = 1'b0;
          end
        end
        OP_FADE_IN, OP_FADE_OUT: begin
          rdy   = 1'b0;
          act   = 1'b1;
          red   = it.color_argb[23:16];
          green = it.color_argb[15:8];
          blue  = it.color_argb[7:0];
          dur   = it.fade_length;
          t0    = it.now_time;
          if (it.operation == OP_FADE_IN) begin
            src_alpha = it.color_argb[31:24];
            dst_alpha = ALPHA_ZERO;
          end else begin
            src_alpha = alpha;
            dst_alpha = it.color_argb[31:24];
          end
        end
        default: begin
          // deactivate keeps colour and alpha
          act = 1'b0;
          rdy = 1'b1;
        end
      endcase
      want.red_out         = red;
      want.green_out       = green;
      want.blue_out        = blue;
      want.alpha_out       = alpha;
      want.is_active       = act;
      want.is_ready        = rdy;
      want.overlay_visible = act && (alpha != ALPHA_ZERO);
      expected_overlay.push_back(want);
    endfunction

    task cmp_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // compare one accepted result beat against the oldest expectation
    task check_beat(result_t got);
      result_t want;
      if (expected_overlay.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_overlay.pop_front();
      if ($isunknown(got)) report($sformatf("result beat has unknown bits: %h", got));
      cmp_field("red_out", got.red_out, want.red_out);
      cmp_field("green_out", got.green_out, want.green_out);
      cmp_field("blue_out", got.blue_out, want.blue_out);
      cmp_field("alpha_out", got.alpha_out, want.alpha_out);
      cmp_field("is_active", got.is_active, want.is_active);
      cmp_field("is_ready", got.is_ready, want.is_ready);
      cmp_field("overlay_visible", got.overlay_visible, want.overlay_visible);
    endtask
  endclass

endpackage

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tafs_pkg::*;
  import tafs_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 600000;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  item_t   in_data;
  logic    out_valid;
  logic    out_stall;
  result_t out_data;

  fade_scoreboard sb;
  item_t          stim_q[$];
  int             cycle_count;

  timed_alpha_fade_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic item_t mk(logic [1:0] op, logic [31:0] color, logic [31:0] len,
                               logic [31:0] now);
    item_t it;
    it.operation   = op;
    it.color_argb  = color;
    it.fade_length = len;
    it.now_time    = now;
    return it;
  endfunction

  // mostly short fades, a few zero and full-range ones
  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2, 3, 4: return $urandom_range(1, 60);
      5, 6, 7: return $urandom_range(61, 5000);
      default: return $urandom;
    endcase
  endfunction

  // edge cases: inactive tick, zero duration, time wrap, falling remainder, deactivate
  task automatic build_directed();
    stim_q.push_back(mk(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    stim_q.push_back(mk(OP_FADE_IN, 32'hFF11_2233, 32'd0, 32'd100));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'd100));
    stim_q.push_back(mk(OP_FADE_OUT, 32'h80AA_BBCC, 32'd100, 32'hFFFF_FFF0));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'h0000_0014));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'h0000_0050));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'h0000_0060));
    stim_q.push_back(mk(OP_FADE_IN, 32'hFF00_0000, 32'd7, 32'd0));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'd3));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'd6));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'd7));
    stim_q.push_back(mk(OP_DEACT, 32'h0, 32'h0, 32'h0));
    stim_q.push_back(mk(OP_FADE_OUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'hFFFF_FFFE));
    stim_q.push_back(mk(OP_DEACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'h0));
    stim_q.push_back(mk(OP_FADE_IN, 32'h00FF_FFFF, 32'd0, 32'hFFFF_FFFF));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'h0));
    stim_q.push_back(mk(OP_FADE_OUT, 32'h0101_0101, 32'd1, 32'd5));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'd5));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'd6));
    stim_q.push_back(mk(OP_FADE_IN, 32'h4000_0000, 32'd1000, 32'd0));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'd500));
    stim_q.push_back(mk(OP_TICK, 32'h0, 32'h0, 32'h8000_0000));
  endtask

  // fade commands followed by ticks with random timing and occasional deactivates, plus raw noise
  task automatic build_random();
    int          target;
    int          n;
    logic [31:0] len;
    logic [31:0] now;
    logic [31:0] step;
    target = stim_q.size() + RANDOM_ITEMS;
    while (stim_q.size() < target) begin
      if ($urandom_range(0, 3) != 0) begin
        len = pick_length();
        now = $urandom;
        stim_q.push_back(mk($urandom_range(0, 1) ? OP_FADE_IN : OP_FADE_OUT,
                            $urandom, len, now));
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 7) == 0) step = $urandom;
          else step = $urandom_range(0, (len >> 2) + 3);
          now += step;
          if ($urandom_range(0, 19) == 0)
            stim_q.push_back(mk(OP_DEACT, $urandom, $urandom, now));
          else
            stim_q.push_back(mk(OP_TICK, $urandom, $urandom, now));
        end
      end else begin
        stim_q.push_back(mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom));
      end
    end
  endtask

  // offer one beat and wait until it is taken
  task automatic send_beat(item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(it);
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  task automatic run_sender();
    int burst;
    while (stim_q.size() != 0) begin
      if ($urandom_range(0, 5) == 0) burst = $urandom_range(20, 60);
      else burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && stim_q.size() != 0; i++) send_beat(stim_q.pop_front());
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 20));
    end
    idle_input(1);
  endtask

  // receiver: stall pattern changes in phases, with two long hold-offs
  initial begin
    int rx_cycles;
    int hold;
    int mode;
    int mode_left;
    rx_cycles = 0;
    hold      = 0;
    mode      = 0;
    mode_left = 0;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles == 3000 || rx_cycles == 15000) hold = 500;
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 400);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= rx_cycles[3];
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_beat(out_data);
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed_alpha_fade_sequencer verification failed");
    $finish;
  end

  // main sequence
  initial begin
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    build_directed();
    build_random();
    run_sender();
    while (sb.expected_overlay.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("timed_alpha_fade_sequencer verification clean");
    end else begin
      $display("timed_alpha_fade_sequencer verification failed");
    end
    $finish;
  end

endmodule
